// ===== rtl/bapa_pkg.sv =====
// types, constants and helpers shared by the address pool allocator
package bapa_pkg;

   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;
   localparam int ADDR_W    = 32;
   localparam int COUNT_W   = 13;
   localparam int STATUS_W  = 3;
   localparam int REQ_W     = 2;
   localparam int POOL_ID_W = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INIT    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;
   localparam logic [REQ_W-1:0] REQ_CLAIM   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOPOOL = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BUSY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REJECT = 3'd4;

   typedef struct packed {
      logic [REQ_W-1:0]     req_type;
      logic [POOL_ID_W-1:0] pool_id;
      logic [ADDR_W-1:0]    address;
      logic [ADDR_W-1:0]    end_address;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   granted_address;
      logic [COUNT_W-1:0]  total_count;
      logic [COUNT_W-1:0]  used_count;
      logic [COUNT_W-1:0]  free_count;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CLEAR,
      S_SCAN,
      S_CHECK,
      S_RESP
   } state_type;

   // index of the lowest set bit, by halving in six steps
   function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] vec);
      logic [WORD_BITS-1:0] v;
      logic [BIT_W-1:0]     idx;
      int                   half;
      v   = vec;
      idx = '0;
      for (int k = BIT_W - 1; k >= 0; k--) begin
         half = 1 << k;
         if ((v & ((64'd1 << half) - 64'd1)) == 64'd0) begin
            idx[k] = 1'b1;
            v      = v >> half;
         end
      end
      return idx;
   endfunction

endpackage

// ===== rtl/bapa_req_if.sv =====
// request channel: valid, ready and the request payload
interface bapa_req_if;
   import bapa_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/bapa_rsp_if.sv =====
// response channel: valid, ready and the response payload
interface bapa_rsp_if;
   import bapa_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/bapa_ram.sv =====
// generic single-write, single-read ram with registered read data
module bapa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bitmap_address_pool_allocator_core.sv =====
// address pool allocator: per-pool registers plus a shared bitmap ram, next-fit search
// sequence: init decodes, zeroes the pool's words one by one, then responds; release and claim
//   read, check and write one word; allocate scans at most ceil(size/64) + 1 bitmap words
// throughput: one request at a time; the bitmap ram read port (one 64-bit word a cycle) sets
//   the allocate time, the clear sweep over the pool's words sets the init time
// reset: all pools marked uninitialized; the bitmap ram is not cleared at reset, a pool's
//   words are zeroed by its init sweep before any read of them
module bitmap_address_pool_allocator_core #(
   parameter int POOL_COUNT = 4,
   parameter int POOL_SLOTS = 4096
) (
   input logic       clock,
   input logic       reset,
   bapa_req_if.sink  req_if,
   bapa_rsp_if.source rsp_if
);
   import bapa_pkg::*;

   // geometry derived from the parameters
   localparam int POOL_WORDS = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int MEM_DEPTH  = POOL_COUNT * POOL_WORDS;
   localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int PW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
   localparam int WW = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
   localparam int CW = $clog2(POOL_SLOTS + 1);
   localparam int SW = $clog2(POOL_SLOTS);

   // control state
   state_type state_ff, state_in;

   // latched request and the first bitmap word of its pool
   req_payload_type q_ff;
   logic [AW-1:0]   wbase_ff;

   // per-pool registers
   logic [ADDR_W-1:0]     base_ff [POOL_COUNT];
   logic [CW-1:0]         size_ff [POOL_COUNT];
   logic [SW-1:0]         hint_ff [POOL_COUNT];
   logic [CW-1:0]         used_ff [POOL_COUNT];
   logic [POOL_COUNT-1:0] valid_ff;

   // scan and sweep bookkeeping
   logic [WW-1:0]    cw_ff, cw_in;
   logic             lap_ff, lap_in;
   logic [WW-1:0]    start_w_ff, start_w_in;
   logic [BIT_W-1:0] sb_ff, sb_in;
   logic [WW-1:0]    last_w_ff, last_w_in;
   logic [SW-1:0]    pos_ff, pos_in;
   logic [WW-1:0]    clr_ff, clr_in;

   // pending result
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [ADDR_W-1:0]   grant_ff, grant_in;
   logic                has_ff, has_in;

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            rsp_load;

   // pool register updates
   logic          upd_init;
   logic          upd_used;
   logic [CW-1:0] used_in;
   logic          upd_hint;
   logic [SW-1:0] hint_in;

   // bitmap ram port
   logic                 rd_en;
   logic [WW-1:0]        rd_word;
   logic                 wr_en;
   logic [WW-1:0]        wr_word;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] rd_data;

   // selected pool view
   logic [PW-1:0]     pidx;
   logic              pool_in_range;
   logic              pool_exists;
   logic [ADDR_W-1:0] base_sel;
   logic [CW-1:0]     size_sel;
   logic [SW-1:0]     hint_sel;
   logic [CW-1:0]     used_sel;
   logic [ADDR_W-1:0] init_size;

   assign pidx          = PW'(q_ff.pool_id);
   assign pool_in_range = int'(q_ff.pool_id) < POOL_COUNT;
   assign pool_exists   = pool_in_range && valid_ff[pidx];
   assign base_sel      = base_ff[pidx];
   assign size_sel      = size_ff[pidx];
   assign hint_sel      = hint_ff[pidx];
   assign used_sel      = used_ff[pidx];
   // range size, wraps modulo 2^32 like the address arithmetic
   assign init_size     = q_ff.end_address - q_ff.address + 32'd1;

   bapa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wbase_ff + AW'(wr_word)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (wbase_ff + AW'(rd_word)),
      .rd_data (rd_data)
   );

   assign req_if.ready   = (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      logic [SW-1:0]        start_pos;
      logic [ADDR_W-1:0]    pos32;
      logic [WORD_BITS-1:0] mask;
      logic [WORD_BITS-1:0] cand;
      logic [BIT_W-1:0]     fbit;
      logic [BIT_W-1:0]     tail;
      logic [SW-1:0]        fpos;
      logic [CW-1:0]        npos;
      logic [CW-1:0]        tot;
      logic [CW-1:0]        usd;

      state_in   = state_ff;
      cw_in      = cw_ff;
      lap_in     = lap_ff;
      start_w_in = start_w_ff;
      sb_in      = sb_ff;
      last_w_in  = last_w_ff;
      pos_in     = pos_ff;
      clr_in     = clr_ff;
      st_in      = st_ff;
      grant_in   = grant_ff;
      has_in     = has_ff;
      rd_en      = 1'b0;
      rd_word    = '0;
      wr_en      = 1'b0;
      wr_word    = '0;
      wr_data    = '0;
      upd_init   = 1'b0;
      upd_used   = 1'b0;
      used_in    = used_sel;
      upd_hint   = 1'b0;
      hint_in    = '0;
      rsp_load   = 1'b0;
      rsp_data_in = rsp_data_ff;

      start_pos = (CW'(hint_sel) >= size_sel) ? '0 : hint_sel;
      pos32     = q_ff.address - base_sel;

      // candidate free bits of the word under scan
      tail = size_sel[BIT_W-1:0];
      mask = '1;
      if (cw_ff == last_w_ff && tail != '0) begin
         mask = mask & ~({WORD_BITS{1'b1}} << tail);
      end
      if (cw_ff == start_w_ff) begin
         if (lap_ff) begin
            mask = mask & ~({WORD_BITS{1'b1}} << sb_ff);
         end else begin
            mask = mask & ({WORD_BITS{1'b1}} << sb_ff);
         end
      end
      cand = ~rd_data & mask;
      fbit = first_set(cand);
      fpos = SW'({cw_ff, fbit});
      npos = CW'(fpos) + CW'(1);

      tot = has_ff ? size_sel : '0;
      usd = has_ff ? used_sel : '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            grant_in = '0;
            has_in   = 1'b1;
            if (q_ff.req_type == REQ_INIT) begin
               if (!pool_in_range || pool_exists || init_size > 32'(POOL_SLOTS)) begin
                  st_in    = ST_REJECT;
                  has_in   = pool_exists;
                  state_in = S_RESP;
               end else begin
                  clr_in   = '0;
                  state_in = S_CLEAR;
               end
            end else if (!pool_exists) begin
               st_in    = ST_NOPOOL;
               has_in   = 1'b0;
               state_in = S_RESP;
            end else begin
               case (q_ff.req_type) inside
                  REQ_ALLOC: begin
                     if (size_sel == '0) begin
                        st_in    = ST_BUSY;
                        state_in = S_RESP;
                     end else begin
                        // first read at the word holding the hint
                        start_w_in = WW'(start_pos >> BIT_W);
                        sb_in      = start_pos[BIT_W-1:0];
                        last_w_in  = WW'((size_sel - CW'(1)) >> BIT_W);
                        cw_in      = WW'(start_pos >> BIT_W);
                        lap_in     = 1'b0;
                        rd_en      = 1'b1;
                        rd_word    = WW'(start_pos >> BIT_W);
                        state_in   = S_SCAN;
                     end
                  end
                  REQ_RELEASE, REQ_CLAIM: begin
                     if (pos32 >= ADDR_W'(size_sel)) begin
                        st_in    = ST_RANGE;
                        state_in = S_RESP;
                     end else begin
                        pos_in   = SW'(pos32);
                        rd_en    = 1'b1;
                        rd_word  = WW'(SW'(pos32) >> BIT_W);
                        state_in = S_CHECK;
                     end
                  end
                  default: begin
                     st_in    = ST_NOPOOL;
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_CLEAR: begin
            // zero one bitmap word a cycle, then commit the pool
            wr_en   = 1'b1;
            wr_word = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + WW'(1);
            if (clr_ff == WW'(POOL_WORDS - 1)) begin
               upd_init = 1'b1;
               st_in    = ST_OK;
               has_in   = 1'b1;
               state_in = S_RESP;
            end
         end

         S_SCAN: begin
            if (cand != '0) begin
               // mark the slot, advance the hint past it
               wr_en    = 1'b1;
               wr_word  = cw_ff;
               wr_data  = rd_data | (64'd1 << fbit);
               upd_used = 1'b1;
               used_in  = used_sel + CW'(1);
               upd_hint = 1'b1;
               hint_in  = (npos == size_sel) ? '0 : SW'(npos);
               grant_in = base_sel + 32'(fpos);
               st_in    = ST_OK;
               state_in = S_RESP;
            end else if (lap_ff && cw_ff == start_w_ff) begin
               st_in    = ST_BUSY;
               state_in = S_RESP;
            end else begin
               // read the next word, wrapping at the pool's last word
               rd_en = 1'b1;
               if (cw_ff == last_w_ff) begin
                  cw_in   = '0;
                  lap_in  = 1'b1;
                  rd_word = '0;
               end else begin
                  cw_in   = cw_ff + WW'(1);
                  rd_word = cw_ff + WW'(1);
               end
            end
         end

         S_CHECK: begin
            st_in    = ST_OK;
            state_in = S_RESP;
            wr_word  = WW'(pos_ff >> BIT_W);
            if (q_ff.req_type == REQ_RELEASE) begin
               if (rd_data[pos_ff[BIT_W-1:0]]) begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data & ~(64'd1 << pos_ff[BIT_W-1:0]);
                  upd_used = 1'b1;
                  used_in  = used_sel - CW'(1);
               end
            end else begin
               if (rd_data[pos_ff[BIT_W-1:0]]) begin
                  st_in = ST_BUSY;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data | (64'd1 << pos_ff[BIT_W-1:0]);
                  upd_used = 1'b1;
                  used_in  = used_sel + CW'(1);
                  grant_in = q_ff.address;
               end
            end
         end

         S_RESP: begin
            // counts are read after the update has landed
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load                    = 1'b1;
               rsp_data_in.status          = st_ff;
               rsp_data_in.granted_address = grant_ff;
               rsp_data_in.total_count     = COUNT_W'(tot);
               rsp_data_in.used_count      = COUNT_W'(usd);
               rsp_data_in.free_count      = COUNT_W'(tot - usd);
               state_in                    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (upd_init) begin
            valid_ff[pidx] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and pool registers
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         q_ff     <= req_if.payload;
         wbase_ff <= AW'(PW'(req_if.payload.pool_id)) * AW'(POOL_WORDS);
      end
      cw_ff      <= cw_in;
      lap_ff     <= lap_in;
      start_w_ff <= start_w_in;
      sb_ff      <= sb_in;
      last_w_ff  <= last_w_in;
      pos_ff     <= pos_in;
      clr_ff     <= clr_in;
      st_ff      <= st_in;
      grant_ff   <= grant_in;
      has_ff     <= has_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (upd_init) begin
         base_ff[pidx] <= q_ff.address;
         size_ff[pidx] <= CW'(init_size);
         hint_ff[pidx] <= '0;
         used_ff[pidx] <= '0;
      end
      if (upd_used) begin
         used_ff[pidx] <= used_in;
      end
      if (upd_hint) begin
         hint_ff[pidx] <= hint_in;
      end
   end

endmodule
